// ===== hw/rtl/mipsdec_pkg.sv =====
// Shared types, codes and decode tables for the MIPS instruction decoder.
package mipsdec_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned IdW    = 7;
	localparam int unsigned ClassW = 4;
	localparam int unsigned RegW   = 5;
	localparam int unsigned ImmW   = 16;

	typedef logic [WordW-1:0]  word_t;
	typedef logic [IdW-1:0]    id_t;
	typedef logic [ClassW-1:0] class_t;
	typedef logic [RegW-1:0]   reg_t;
	typedef logic [5:0]        opcode_t;

	localparam opcode_t OP_SPECIAL = 6'h00;
	localparam opcode_t OP_REGIMM  = 6'h01;
	localparam opcode_t OP_COP0    = 6'h10;
	localparam reg_t    COP0_MF    = 5'h00;
	localparam reg_t    COP0_MT    = 5'h04;
	localparam word_t   ERET_WORD  = 32'h4200_0018;

	localparam id_t ID_UNKNOWN      = 7'd78;
	localparam id_t ID_BRANCH_FIRST = 7'd6;
	localparam id_t ID_BRANCH_LAST  = 7'd21;
	localparam id_t ID_ERET         = 7'd25;
	localparam id_t ID_J            = 7'd26;
	localparam id_t ID_JAL          = 7'd27;
	localparam id_t ID_MFC0         = 7'd36;
	localparam id_t ID_MTC0         = 7'd39;
	localparam id_t ID_NOP          = 7'd44;
	localparam id_t ID_SLL          = 7'd50;

	localparam class_t CLASS_OF_ID [79] = '{
		4'h0, 4'h3, 4'h3, 4'h0, 4'h0, 4'h3, 4'h5, 4'h5, 4'ha, 4'ha,
		4'ha, 4'ha, 4'ha, 4'ha, 4'ha, 4'ha, 4'ha, 4'ha, 4'ha, 4'ha,
		4'h5, 4'h5, 4'he, 4'hf, 4'hf, 4'he, 4'hb, 4'hb, 4'h6, 4'hc,
		4'h4, 4'h4, 4'h4, 4'h4, 4'h9, 4'h4, 4'h7, 4'hd, 4'hd, 4'h7,
		4'hc, 4'hc, 4'hf, 4'hf, 4'he, 4'h0, 4'h0, 4'h3, 4'h4, 4'h4,
		4'h2, 4'h1, 4'h0, 4'h3, 4'h3, 4'h0, 4'h2, 4'h1, 4'h2, 4'h1,
		4'h0, 4'h0, 4'h4, 4'he, 4'hf, 4'h8, 4'hf, 4'h8, 4'h8, 4'hf,
		4'hf, 4'h8, 4'h8, 4'hf, 4'hf, 4'h8, 4'h0, 4'h3, 4'h0
	};

	function automatic class_t class_of(input id_t id);
		class_t c;
		if (id <= ID_UNKNOWN) begin
			c = CLASS_OF_ID[id];
		end else begin
			c = '0;
		end
		return c;
	endfunction

	function automatic id_t primary_id(input opcode_t op);
		id_t id;
		case (op)
			6'd2: id = 7'd26;
			6'd3: id = 7'd27;
			6'd4: id = 7'd6;
			6'd5: id = 7'd20;
			6'd6: id = 7'd14;
			6'd7: id = 7'd12;
			6'd8: id = 7'd1;
			6'd9: id = 7'd2;
			6'd10: id = 7'd53;
			6'd11: id = 7'd54;
			6'd12: id = 7'd5;
			6'd13: id = 7'd47;
			6'd14: id = 7'd77;
			6'd15: id = 7'd34;
			6'd20: id = 7'd7;
			6'd21: id = 7'd21;
			6'd22: id = 7'd15;
			6'd23: id = 7'd13;
			6'd32: id = 7'd30;
			6'd33: id = 7'd32;
			6'd35: id = 7'd35;
			6'd36: id = 7'd31;
			6'd37: id = 7'd33;
			6'd40: id = 7'd48;
			6'd41: id = 7'd49;
			6'd43: id = 7'd62;
			default: id = ID_UNKNOWN;
		endcase
		return id;
	endfunction

	function automatic id_t funct_id(input logic [5:0] fn);
		id_t id;
		case (fn)
			6'd0: id = 7'd50;
			6'd2: id = 7'd58;
			6'd3: id = 7'd56;
			6'd4: id = 7'd51;
			6'd6: id = 7'd59;
			6'd7: id = 7'd57;
			6'd8: id = 7'd29;
			6'd9: id = 7'd28;
			6'd12: id = 7'd63;
			6'd13: id = 7'd22;
			6'd16: id = 7'd37;
			6'd17: id = 7'd40;
			6'd18: id = 7'd38;
			6'd19: id = 7'd41;
			6'd24: id = 7'd42;
			6'd25: id = 7'd43;
			6'd26: id = 7'd23;
			6'd27: id = 7'd24;
			6'd32: id = 7'd0;
			6'd33: id = 7'd3;
			6'd34: id = 7'd60;
			6'd35: id = 7'd61;
			6'd36: id = 7'd4;
			6'd37: id = 7'd46;
			6'd38: id = 7'd76;
			6'd39: id = 7'd45;
			6'd42: id = 7'd52;
			6'd43: id = 7'd55;
			6'd48: id = 7'd66;
			6'd49: id = 7'd69;
			6'd50: id = 7'd70;
			6'd51: id = 7'd73;
			6'd52: id = 7'd64;
			6'd54: id = 7'd74;
			default: id = ID_UNKNOWN;
		endcase
		return id;
	endfunction

	function automatic id_t regimm_id(input reg_t rt);
		id_t id;
		case (rt)
			5'd0: id = 7'd16;
			5'd1: id = 7'd8;
			5'd2: id = 7'd19;
			5'd3: id = 7'd11;
			5'd8: id = 7'd67;
			5'd9: id = 7'd68;
			5'd10: id = 7'd71;
			5'd11: id = 7'd72;
			5'd12: id = 7'd65;
			5'd14: id = 7'd75;
			5'd16: id = 7'd17;
			5'd17: id = 7'd9;
			5'd18: id = 7'd18;
			5'd19: id = 7'd10;
			default: id = ID_UNKNOWN;
		endcase
		return id;
	endfunction

endpackage

// ===== hw/rtl/mipsdec_if.sv =====
// Valid/ready channel interfaces for instruction words in and decoded results out.
interface mipsdec_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;
	logic [31:0] pc;

	modport source (output valid, output instruction_word, output pc, input ready);
	modport sink (input valid, input instruction_word, input pc, output ready);
endinterface

interface mipsdec_out_if;
	logic               valid;
	logic               ready;
	logic [6:0]         instruction_id;
	logic [3:0]         operand_class;
	logic [4:0]         reg_s;
	logic [4:0]         reg_t;
	logic [4:0]         reg_d;
	logic [4:0]         shift_amount;
	logic signed [15:0] imm_signed;
	logic [31:0]        flow_target;

	modport source (
		output valid, output instruction_id, output operand_class, output reg_s,
		output reg_t, output reg_d, output shift_amount, output imm_signed,
		output flow_target, input ready
	);
	modport sink (
		input valid, input instruction_id, input operand_class, input reg_s,
		input reg_t, input reg_d, input shift_amount, input imm_signed,
		input flow_target, output ready
	);
endinterface

// ===== hw/rtl/mipsdec_id.sv =====
// Instruction id lookup through the opcode, funct, REGIMM and COP0 tables.
module mipsdec_id (
	input  mipsdec_pkg::word_t word,
	output mipsdec_pkg::id_t   id
);
	import mipsdec_pkg::*;

	opcode_t op;
	reg_t    rs;
	id_t     raw_id;

	assign op = word[31:26];
	assign rs = word[25:21];

	always_comb begin
		case (op)
			OP_SPECIAL: raw_id = funct_id(word[5:0]);
			OP_REGIMM: raw_id = regimm_id(word[20:16]);
			OP_COP0: begin
				if (word == ERET_WORD) begin
					raw_id = ID_ERET;
				end else if (rs == COP0_MF) begin
					raw_id = ID_MFC0;
				end else if (rs == COP0_MT) begin
					raw_id = ID_MTC0;
				end else begin
					raw_id = ID_UNKNOWN;
				end
			end
			default: raw_id = primary_id(op);
		endcase
	end

	assign id = (raw_id == ID_SLL && word == '0) ? ID_NOP : raw_id;
endmodule

// ===== hw/rtl/mips_instruction_decoder.sv =====
// MIPS32 instruction decoder top level: a three-stage valid/ready pipeline.
// One instruction word and its address enter per beat and every beat yields exactly one
// decoded result. The pipeline has three register stages (input capture, table lookup with
// pc + 4, then format class and branch or jump target). An accepted beat passes through
// the input, middle and output registers in that order. A new beat can be taken in every
// cycle while the output is being drained. Each stage holds its contents while the stage
// after it is full and stalled, so once every stage is full, backpressure on the result
// side stops the input within the same cycle without losing or repeating a beat. The flow
// target is pc + 4 plus the scaled immediate for conditional branches, the region of pc + 4
// joined with the scaled index for J and JAL, and zero otherwise.
module mips_instruction_decoder (
	input  logic          clk,
	input  logic          arst_n,
	mipsdec_in_if.sink    request,
	mipsdec_out_if.source result
);
	import mipsdec_pkg::*;

	logic  en_s1, en_s2, en_s3;
	logic  v_s1, v_s2, v_s3;
	word_t word_s1, pc_s1;
	word_t word_s2, next_s2;
	id_t   id_s2, id_dec;
	id_t   id_s3;
	class_t class_s3;
	word_t word_s3, target_s3;
	word_t target_d;
	logic  is_branch, is_jump;

	assign en_s3 = !v_s3 || result.ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign request.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= request.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && request.valid) begin
			word_s1 <= request.instruction_word;
			pc_s1   <= request.pc;
		end
	end

	mipsdec_id u_id (
		.word (word_s1),
		.id   (id_dec)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			word_s2 <= word_s1;
			id_s2   <= id_dec;
			next_s2 <= pc_s1 + 32'd4;
		end
	end

	assign is_branch = (id_s2 >= ID_BRANCH_FIRST) && (id_s2 <= ID_BRANCH_LAST);
	assign is_jump   = (id_s2 == ID_J) || (id_s2 == ID_JAL);

	always_comb begin
		if (is_branch) begin
			target_d = next_s2 + {{14{word_s2[15]}}, word_s2[15:0], 2'b00};
		end else if (is_jump) begin
			target_d = {next_s2[31:28], word_s2[25:0], 2'b00};
		end else begin
			target_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			word_s3   <= word_s2;
			id_s3     <= id_s2;
			class_s3  <= class_of(id_s2);
			target_s3 <= target_d;
		end
	end

	assign result.valid          = v_s3;
	assign result.instruction_id = id_s3;
	assign result.operand_class  = class_s3;
	assign result.reg_s          = word_s3[25:21];
	assign result.reg_t          = word_s3[20:16];
	assign result.reg_d          = word_s3[15:11];
	assign result.shift_amount   = word_s3[10:6];
	assign result.imm_signed     = $signed(word_s3[15:0]);
	assign result.flow_target    = target_s3;

`ifndef SYNTHESIS
	a_unknown_class: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && id_s3 == ID_UNKNOWN |-> class_s3 == '0)
		else $error("Unknown instruction carries a nonzero class.");

	a_target_only_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && target_s3 != '0 |->
			(id_s3 >= ID_BRANCH_FIRST && id_s3 <= ID_BRANCH_LAST) ||
			id_s3 == ID_J || id_s3 == ID_JAL)
		else $error("Flow target set for an instruction that is not a branch or jump.");

	a_nop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && id_s3 == ID_NOP |-> word_s3 == '0)
		else $error("NOP decoded from a nonzero word.");

	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en_s3 |=> v_s2 && $stable(id_s2) && $stable(word_s2))
		else $error("Middle stage changed while the output stage was stalled.");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en_s2 |=> v_s1 && $stable(word_s1) && $stable(pc_s1))
		else $error("Input stage changed while the middle stage was stalled.");
`endif
endmodule

// ===== sim/tb_mips_instruction_decoder.sv =====
// Self-checking testbench for the MIPS instruction decoder, with a directed table and random beats.
`timescale 1ns / 1ps

module tb_mips_instruction_decoder;
	import mipsdec_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1300;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam id_t NA = ID_UNKNOWN;

	typedef struct packed {
		id_t                id;
		class_t             cls;
		reg_t               rs;
		reg_t               rt;
		reg_t               rd;
		reg_t               sa;
		logic signed [15:0] imm;
		word_t              target;
	} decoded_t;

	typedef struct packed {
		word_t    word;
		word_t    pc;
		logic     typed;
		decoded_t want;
	} stim_row_t;

	localparam id_t PRIMARY_TAB [64] = '{
		NA, NA, 26, 27, 6, 20, 14, 12, 1, 2, 53, 54, 5, 47, 77, 34,
		NA, NA, NA, NA, 7, 21, 15, 13, NA, NA, NA, NA, NA, NA, NA, NA,
		30, 32, NA, 35, 31, 33, NA, NA, 48, 49, NA, 62, NA, NA, NA, NA,
		NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA
	};

	localparam id_t FUNCT_TAB [64] = '{
		50, NA, 58, 56, 51, NA, 59, 57, 29, 28, NA, NA, 63, 22, NA, NA,
		37, 40, 38, 41, NA, NA, NA, NA, 42, 43, 23, 24, NA, NA, NA, NA,
		0, 3, 60, 61, 4, 46, 76, 45, NA, NA, 52, 55, NA, NA, NA, NA,
		66, 69, 70, 73, 64, NA, 74, NA, NA, NA, NA, NA, NA, NA, NA, NA
	};

	localparam id_t REGIMM_TAB [32] = '{
		16, 8, 19, 11, NA, NA, NA, NA, 67, 68, 71, 72, 65, NA, 75, NA,
		17, 9, 18, 10, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA
	};

	localparam class_t FORMAT_TAB [79] = '{
		4'h0, 4'h3, 4'h3, 4'h0, 4'h0, 4'h3, 4'h5, 4'h5, 4'ha, 4'ha,
		4'ha, 4'ha, 4'ha, 4'ha, 4'ha, 4'ha, 4'ha, 4'ha, 4'ha, 4'ha,
		4'h5, 4'h5, 4'he, 4'hf, 4'hf, 4'he, 4'hb, 4'hb, 4'h6, 4'hc,
		4'h4, 4'h4, 4'h4, 4'h4, 4'h9, 4'h4, 4'h7, 4'hd, 4'hd, 4'h7,
		4'hc, 4'hc, 4'hf, 4'hf, 4'he, 4'h0, 4'h0, 4'h3, 4'h4, 4'h4,
		4'h2, 4'h1, 4'h0, 4'h3, 4'h3, 4'h0, 4'h2, 4'h1, 4'h2, 4'h1,
		4'h0, 4'h0, 4'h4, 4'he, 4'hf, 4'h8, 4'hf, 4'h8, 4'h8, 4'hf,
		4'hf, 4'h8, 4'h8, 4'hf, 4'hf, 4'h8, 4'h0, 4'h3, 4'h0
	};

	localparam stim_row_t DIRECTED [22] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1,
			'{ID_NOP, 4'he, 5'd0, 5'd0, 5'd0, 5'd0, 16'sh0000, 32'h0}},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{ID_UNKNOWN, 4'h0, 5'd31, 5'd31, 5'd31, 5'd31, 16'shFFFF, 32'h0}},
		'{ERET_WORD, 32'h0000_0100, 1'b1,
			'{ID_ERET, 4'he, 5'h10, 5'd0, 5'd0, 5'd0, 16'sh0018, 32'h0}},
		'{32'h4020_0000, 32'h0000_0000, 1'b1,
			'{ID_UNKNOWN, 4'h0, 5'd1, 5'd0, 5'd0, 5'd0, 16'sh0000, 32'h0}},
		'{32'h0000_0001, 32'h1234_5678, 1'b1,
			'{ID_UNKNOWN, 4'h0, 5'd0, 5'd0, 5'd0, 5'd0, 16'sh0001, 32'h0}},
		'{32'h0404_0000, 32'h0000_0000, 1'b1,
			'{ID_UNKNOWN, 4'h0, 5'd0, 5'd4, 5'd0, 5'd0, 16'sh0000, 32'h0}},
		'{32'hFC00_0000, 32'h8000_0000, 1'b1,
			'{ID_UNKNOWN, 4'h0, 5'd0, 5'd0, 5'd0, 5'd0, 16'sh0000, 32'h0}},
		'{32'h4001_2000, 32'h0000_0040, 1'b0, '0},
		'{32'h4081_1000, 32'h0000_0044, 1'b0, '0},
		'{32'h0002_1080, 32'h0000_0048, 1'b0, '0},
		'{32'h0232_4020, 32'h0040_0000, 1'b0, '0},
		'{32'h03E0_0008, 32'h0040_0004, 1'b0, '0},
		'{32'h1000_FFFF, 32'h0000_0000, 1'b0, '0},
		'{32'h1422_7FFF, 32'hFFFF_FFFC, 1'b0, '0},
		'{32'h0BFF_FFFF, 32'hEFFF_FFFC, 1'b0, '0},
		'{32'h0C00_0000, 32'hFFFF_FFFC, 1'b0, '0},
		'{32'h0411_8000, 32'h0000_1000, 1'b0, '0},
		'{32'h5000_0001, 32'h7FFF_FFF8, 1'b0, '0},
		'{32'h2008_8000, 32'h0000_2000, 1'b0, '0},
		'{32'h3C01_7FFF, 32'h0000_2004, 1'b0, '0},
		'{32'h8FFF_FFFC, 32'h0000_2008, 1'b0, '0},
		'{32'h0000_000C, 32'h0000_200C, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic steady;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	decoded_t decode_q [$];

	mipsdec_in_if  req_if ();
	mipsdec_out_if res_if ();

	mips_instruction_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_if),
		.result (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic decoded_t decode_word(input word_t w, input word_t addr);
		decoded_t d;
		id_t      id;
		word_t    next;
		word_t    simm;
		case (w[31:26])
			OP_SPECIAL: id = FUNCT_TAB[w[5:0]];
			OP_REGIMM:  id = REGIMM_TAB[w[20:16]];
			OP_COP0: begin
				if (w == ERET_WORD) id = ID_ERET;
				else if (w[25:21] == COP0_MF) id = ID_MFC0;
				else if (w[25:21] == COP0_MT) id = ID_MTC0;
				else id = ID_UNKNOWN;
			end
			default: id = PRIMARY_TAB[w[31:26]];
		endcase
		if (id == ID_SLL && w == '0) id = ID_NOP;
		simm = {{16{w[15]}}, w[15:0]};
		next = addr + 32'd4;
		d.target = '0;
		if (id >= ID_BRANCH_FIRST && id <= ID_BRANCH_LAST) begin
			d.target = next + (simm << 2);
		end else if (id == ID_J || id == ID_JAL) begin
			d.target = {next[31:28], w[25:0], 2'b00};
		end
		d.id  = id;
		d.cls = FORMAT_TAB[id];
		d.rs  = w[25:21];
		d.rt  = w[20:16];
		d.rd  = w[15:11];
		d.sa  = w[10:6];
		d.imm = w[15:0];
		return d;
	endfunction

	function automatic word_t random_word();
		word_t w;
		int unsigned pick;
		w = $urandom;
		pick = $urandom_range(99);
		if (pick < 30) begin
			w[31:26] = OP_SPECIAL;
		end else if (pick < 40) begin
			w[31:26] = OP_REGIMM;
		end else if (pick < 50) begin
			w[31:26] = OP_COP0;
			case ($urandom_range(3))
				0: w[25:21] = COP0_MF;
				1: w[25:21] = COP0_MT;
				2: w = ERET_WORD;
				default: ;
			endcase
		end else if (pick < 53) begin
			w = '0;
		end
		return w;
	endfunction

	function automatic word_t random_pc();
		word_t a;
		a = $urandom;
		case ($urandom_range(9))
			0: a = 32'hFFFF_FFFF - $urandom_range(15);
			1: a[27:0] = 28'hFFF_FFFC;
			default: ;
		endcase
		return a;
	endfunction

	task automatic send_instr(input word_t w, input word_t addr, input logic typed,
			input decoded_t want);
		while (!steady && $urandom_range(99) < 36) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.instruction_word = w;
		req_if.pc = addr;
		do @(posedge clk); while (!req_if.ready);
		decode_q.insert(decode_q.size(), typed ? want : decode_word(w, addr));
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_if.valid = 1'b0;
		while (decode_q.size() != 0) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(negedge clk) begin
		res_if.ready = steady || ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (decode_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, got id %0d", $time,
					res_if.instruction_id);
			end else begin
				want = decode_q.pop_front();
				check_field("instruction_id", 32'(want.id), 32'(res_if.instruction_id));
				check_field("operand_class", 32'(want.cls), 32'(res_if.operand_class));
				check_field("reg_s", 32'(want.rs), 32'(res_if.reg_s));
				check_field("reg_t", 32'(want.rt), 32'(res_if.reg_t));
				check_field("reg_d", 32'(want.rd), 32'(res_if.reg_d));
				check_field("shift_amount", 32'(want.sa), 32'(res_if.shift_amount));
				check_field("imm_signed", 32'(want.imm), 32'(res_if.imm_signed));
				check_field("flow_target", want.target, res_if.flow_target);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		arst_n = 1'b0;
		steady = 1'b0;
		req_if.valid = 1'b0;
		req_if.instruction_word = '0;
		req_if.pc = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i]) begin
			send_instr(DIRECTED[i].word, DIRECTED[i].pc, DIRECTED[i].typed, DIRECTED[i].want);
		end
		drain_results();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 500 && n < 800);
			if (n == 1000) drain_results();
			send_instr(random_word(), random_pc(), 1'b0, '0);
		end
		steady = 1'b0;
		drain_results();
		repeat (8) @(posedge clk);

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mipsdec_pkg.sv
hw/rtl/mipsdec_if.sv
hw/rtl/mipsdec_id.sv
hw/rtl/mips_instruction_decoder.sv
sim/tb_mips_instruction_decoder.sv
